[hdl/smhpd_pkg.sv]
// smhpd_pkg: types, widths and constants shared by the max-hold peak decimator
// used by the channel interfaces and every module of the block; no dependencies
`timescale 1ns / 1ps

package smhpd_pkg;

  localparam int FREQ_W = 23;
  localparam int AMP_W  = 16;
  localparam int IDX_W  = 12;
  localparam int CNT_W  = 13;
  localparam int ONB_W  = 25;
  localparam int PM_W   = 25;
  localparam int REG_W  = 3;

  localparam logic [CNT_W-1:0] MAX_POINTS  = 13'd4096;
  localparam logic [CNT_W-1:0] MIN_BUCKETS = 13'd64;
  localparam logic signed [AMP_W-1:0] HOLD_FLOOR = -16'sd15000;

  localparam logic [CNT_W-1:0] SWEEP_POINTS_RST = 13'd4096;
  localparam logic [IDX_W-1:0] WINDOW_FIRST_RST = 12'd0;
  localparam logic [IDX_W-1:0] WINDOW_LAST_RST  = 12'd4095;
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 13'd1024;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef logic [FREQ_W-1:0]        freq_t;
  typedef logic signed [AMP_W-1:0]  amp_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [REG_W-1:0] {
    REG_SWEEP_POINTS = 3'd0,
    REG_WINDOW_FIRST = 3'd1,
    REG_WINDOW_LAST  = 3'd2,
    REG_BUCKET_COUNT = 3'd3,
    REG_HOLD_ENABLE  = 3'd4
  } cfg_reg_t;

  // one classified sample on its way from the front to the back
  typedef struct packed {
    freq_t              frequency;
    amp_t               amplitude;
    idx_t               idx;
    logic               in_win;
    logic               first;
    logic               last;
    logic [ONB_W-1:0]   onb;
  } q_ent_t;

  // settled configuration seen by the back
  typedef struct packed {
    cnt_t m;
    cnt_t nb;
    logic pass;
    logic hold_en;
    logic clear;
  } cfgd_t;

endpackage

[hdl/smhpd_ifs.sv]
// smhpd_ifs: valid/ready channel interfaces for samples, points and register writes
// depends on smhpd_pkg
`timescale 1ns / 1ps

interface smhpd_in_if import smhpd_pkg::*; ();
  logic  valid;
  logic  ready;
  freq_t frequency;
  amp_t  amplitude;

  modport source (output valid, output frequency, output amplitude, input ready);
  modport sink   (input valid, input frequency, input amplitude, output ready);
endinterface

interface smhpd_out_if import smhpd_pkg::*; ();
  logic  valid;
  logic  ready;
  freq_t point_frequency;
  amp_t  live_peak;
  amp_t  hold_peak;
  logic  hold_valid;
  logic  trace_end;

  modport source (output valid, output point_frequency, output live_peak, output hold_peak,
                  output hold_valid, output trace_end, input ready);
  modport sink   (input valid, input point_frequency, input live_peak, input hold_peak,
                  input hold_valid, input trace_end, output ready);
endinterface

interface smhpd_cfg_if import smhpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] index;
  logic [CNT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/smhpd_queue.sv]
// smhpd_queue: short fifo of classified samples between front and back
// depends on smhpd_pkg
`timescale 1ns / 1ps

module smhpd_queue import smhpd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  q_ent_t push_ent,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output q_ent_t head_ent
);

  q_ent_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_ent   = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = Q_CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = Q_CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

[hdl/smhpd_front.sv]
// smhpd_front: register file, settled window/bucket setup, sample index and
// classification of each accepted sample into the queue; depends on smhpd_pkg, smhpd_ifs
`timescale 1ns / 1ps

module smhpd_front import smhpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  smhpd_in_if.sink    in_ch,
  smhpd_cfg_if.sink   cfg_ch,
  input  logic        q_full,
  output logic        q_push,
  output q_ent_t      q_ent,
  output cfgd_t       cfgd
);

  cnt_t       sweep_points_r;
  idx_t       window_first_r;
  idx_t       window_last_r;
  cnt_t       bucket_count_r;
  logic       hold_enable_r;

  // settled setup, recomputed every cycle
  idx_t       nm1_r, nm1_nxt;
  idx_t       wf_r, wf_nxt;
  idx_t       wl_r, wl_nxt;
  cnt_t       m_r, m_nxt;
  cnt_t       nb_r, nb_nxt;
  logic       pass_r, pass_nxt;

  logic [1:0] settle_r, settle_nxt;
  idx_t       idx_r, idx_nxt;
  cnt_t       n_c;
  idx_t       wl_c;
  idx_t       off;
  logic       cfg_fire, in_fire, sweep_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign sweep_wr     = cfg_fire && (cfg_reg_t'(cfg_ch.index) == REG_SWEEP_POINTS);
  assign in_ch.ready  = !q_full && (settle_r == '0);
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_points_r <= SWEEP_POINTS_RST;
      window_first_r <= WINDOW_FIRST_RST;
      window_last_r  <= WINDOW_LAST_RST;
      bucket_count_r <= BUCKET_COUNT_RST;
      hold_enable_r  <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_SWEEP_POINTS: sweep_points_r <= cfg_ch.data;
        REG_WINDOW_FIRST: window_first_r <= cfg_ch.data[IDX_W-1:0];
        REG_WINDOW_LAST:  window_last_r  <= cfg_ch.data[IDX_W-1:0];
        REG_BUCKET_COUNT: bucket_count_r <= cfg_ch.data;
        REG_HOLD_ENABLE:  hold_enable_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sweep_points_r == '0) begin
      n_c = 13'd1;
    end else if (sweep_points_r > MAX_POINTS) begin
      n_c = MAX_POINTS;
    end else begin
      n_c = sweep_points_r;
    end
    nm1_nxt = IDX_W'(n_c - 13'd1);
    wl_c    = (window_last_r > nm1_nxt) ? nm1_nxt : window_last_r;
    // window below its start covers the whole sweep
    if (wl_c < window_first_r) begin
      wf_nxt = '0;
      wl_nxt = nm1_nxt;
    end else begin
      wf_nxt = window_first_r;
      wl_nxt = wl_c;
    end
    m_nxt    = CNT_W'({1'b0, wl_nxt} - {1'b0, wf_nxt} + 13'd1);
    nb_nxt   = (bucket_count_r < MIN_BUCKETS) ? MIN_BUCKETS : bucket_count_r;
    pass_nxt = (m_nxt <= nb_nxt);
  end

  always_ff @(posedge clk) begin
    nm1_r  <= nm1_nxt;
    wf_r   <= wf_nxt;
    wl_r   <= wl_nxt;
    m_r    <= m_nxt;
    nb_r   <= nb_nxt;
    pass_r <= pass_nxt;
  end

  // hold off samples until the setup registers reflect the last write
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_fire) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = 2'(settle_r - 1'b1);
    end
    idx_nxt = idx_r;
    if (sweep_wr) begin
      idx_nxt = '0;
    end else if (in_fire) begin
      idx_nxt = (idx_r == nm1_r) ? '0 : IDX_W'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
      idx_r    <= '0;
    end else begin
      settle_r <= settle_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_comb begin
    off             = IDX_W'(idx_r - wf_r);
    q_push          = in_fire;
    q_ent.frequency = in_ch.frequency;
    q_ent.amplitude = in_ch.amplitude;
    q_ent.idx       = idx_r;
    q_ent.in_win    = (idx_r >= wf_r) && (idx_r <= wl_r);
    q_ent.first     = (idx_r == wf_r);
    q_ent.last      = (idx_r == wl_r);
    q_ent.onb       = ONB_W'(ONB_W'(off) * ONB_W'(nb_r));
  end

  assign cfgd.m       = m_r;
  assign cfgd.nb      = nb_r;
  assign cfgd.pass    = pass_r;
  assign cfgd.hold_en = hold_enable_r;
  assign cfgd.clear   = sweep_wr;

endmodule

[hdl/smhpd_back.sv]
// smhpd_back: max-hold store update, bucket boundary tracking, peak reduction
// and the output register; depends on smhpd_pkg, smhpd_ifs
`timescale 1ns / 1ps

module smhpd_back import smhpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfgd_t       cfgd,
  input  logic        q_valid,
  input  q_ent_t      q_head,
  output logic        q_pop,
  smhpd_out_if.source out_ch
);

  amp_t               hold_mem [1 << IDX_W];

  logic               b_valid_r;
  q_ent_t             b_ent_r;
  amp_t               rd_data_r;
  logic               fwd_r;
  amp_t               fwd_val_r;

  cnt_t               bkt_r, bkt_nxt;
  logic [PM_W-1:0]    pm_r, pm_nxt;
  freq_t              ff_r, ff_nxt;
  amp_t               live_r, live_nxt;
  amp_t               hmax_r, hmax_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;

  logic               out_valid_r;
  freq_t              out_freq_r;
  amp_t               out_live_r;
  amp_t               out_hold_r;
  logic               out_hv_r;
  logic               out_end_r;

  logic               b_fire;
  amp_t               hold_old, h;
  cnt_t               bkt_e;
  logic [PM_W-1:0]    pm_e;
  logic [PM_W:0]      lo, pm_x;
  logic               start_hit, end_hit, emit;
  freq_t              ff_c, pt_freq;
  amp_t               live_c, hmax_c, pt_live, pt_hold;

  assign b_fire = b_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop  = q_valid && (!b_valid_r || b_fire);

  always_comb begin
    // never-written bins read as the floor
    if (fwd_r) begin
      hold_old = fwd_val_r;
    end else if ({1'b0, b_ent_r.idx} < fill_r) begin
      hold_old = rd_data_r;
    end else begin
      hold_old = HOLD_FLOOR;
    end
    h = (b_ent_r.amplitude > hold_old) ? b_ent_r.amplitude : hold_old;

    // window offset zero restarts at bucket 0
    bkt_e = b_ent_r.first ? '0 : bkt_r;
    pm_e  = b_ent_r.first ? '0 : pm_r;
    lo    = {1'b0, b_ent_r.onb};
    pm_x  = {1'b0, pm_e};

    // o == floor(b*m/nb) and o+1 >= floor((b+1)*m/nb), without dividing
    start_hit = b_ent_r.first || ((pm_x >= lo) && (pm_x < lo + (PM_W+1)'(cfgd.nb)));
    end_hit   = (pm_x + (PM_W+1)'(cfgd.m) < lo + (PM_W+1)'(cfgd.nb) + (PM_W+1)'(cfgd.nb))
                && (bkt_e < cfgd.nb);

    if (start_hit) begin
      ff_c   = b_ent_r.frequency;
      live_c = b_ent_r.amplitude;
      hmax_c = h;
    end else begin
      ff_c   = ff_r;
      live_c = (b_ent_r.amplitude > live_r) ? b_ent_r.amplitude : live_r;
      hmax_c = (h > hmax_r) ? h : hmax_r;
    end

    emit = b_ent_r.in_win && (cfgd.pass || end_hit);
    if (cfgd.pass) begin
      pt_freq = b_ent_r.frequency;
      pt_live = b_ent_r.amplitude;
      pt_hold = h;
    end else begin
      pt_freq = FREQ_W'(({1'b0, ff_c} + {1'b0, b_ent_r.frequency}) >> 1);
      pt_live = live_c;
      pt_hold = hmax_c;
    end
  end

  always_comb begin
    bkt_nxt  = bkt_r;
    pm_nxt   = pm_r;
    ff_nxt   = ff_r;
    live_nxt = live_r;
    hmax_nxt = hmax_r;
    fill_nxt = fill_r;
    if (cfgd.clear) begin
      bkt_nxt  = '0;
      pm_nxt   = '0;
      ff_nxt   = '0;
      live_nxt = HOLD_FLOOR;
      hmax_nxt = HOLD_FLOOR;
      fill_nxt = '0;
    end else if (b_fire) begin
      if ({1'b0, b_ent_r.idx} == fill_r) begin
        fill_nxt = CNT_W'(fill_r + 1'b1);
      end
      if (b_ent_r.in_win && !cfgd.pass) begin
        ff_nxt   = ff_c;
        live_nxt = live_c;
        hmax_nxt = hmax_c;
        bkt_nxt  = end_hit ? CNT_W'(bkt_e + 1'b1) : bkt_e;
        pm_nxt   = end_hit ? PM_W'(pm_x + (PM_W+1)'(cfgd.m)) : pm_e;
      end
    end else if (!b_valid_r) begin
      // between samples keep b*m in step with the current setup
      pm_nxt = PM_W'((PM_W+1)'(bkt_r) * (PM_W+1)'(cfgd.m));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_r  <= '0;
      pm_r   <= '0;
      ff_r   <= '0;
      live_r <= HOLD_FLOOR;
      hmax_r <= HOLD_FLOOR;
      fill_r <= '0;
    end else begin
      bkt_r  <= bkt_nxt;
      pm_r   <= pm_nxt;
      ff_r   <= ff_nxt;
      live_r <= live_nxt;
      hmax_r <= hmax_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      hold_mem[b_ent_r.idx] <= h;
    end
    if (q_pop) begin
      rd_data_r <= hold_mem[q_head.idx];
      b_ent_r   <= q_head;
      // bin written at this same edge by the sample leaving the stage
      fwd_r     <= b_fire && (b_ent_r.idx == q_head.idx);
      fwd_val_r <= h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && emit) begin
      out_freq_r <= pt_freq;
      out_live_r <= pt_live;
      out_hold_r <= cfgd.hold_en ? pt_hold : '0;
      out_hv_r   <= cfgd.hold_en;
      out_end_r  <= b_ent_r.last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.point_frequency = out_freq_r;
  assign out_ch.live_peak       = out_live_r;
  assign out_ch.hold_peak       = out_hold_r;
  assign out_ch.hold_valid      = out_hv_r;
  assign out_ch.trace_end       = out_end_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_POINTS)
    else $error("fill count past store depth");

  a_bucket_restart: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_ent_r.in_win && b_ent_r.first && !cfgd.pass && !cfgd.clear
      |=> bkt_r <= 13'd1)
    else $error("window start did not restart bucket numbering");

  a_pass_emits: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_ent_r.in_win && cfgd.pass |=> out_valid_r)
    else $error("pass-through sample produced no point");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_fire))
    else $error("point appeared without a completed sample");

endmodule

[hdl/spectrum_max_hold_peak_decimator_unit.sv]
// spectrum_max_hold_peak_decimator_unit: top level of the max-hold peak decimator
// depends on smhpd_pkg, smhpd_ifs, smhpd_front, smhpd_queue, smhpd_back
`timescale 1ns / 1ps

// Usage:
//   in_ch  : one sweep sample per transaction (frequency in kHz, amplitude in
//            0.01 dBm). The sample index is counted inside and wraps at the sweep length.
//   out_ch : one point per completed bucket, or per window sample when the
//            window holds no more samples than the bucket count.
//   cfg_ch : register writes (index 0..4), always ready. Write only while idle;
//            in_ch.ready drops after every write while the window and bucket
//            setup settle. Writing sweep_points clears the max-hold store and
//            restarts the sweep.
// Throughput: one sample per cycle sustained while out_ch.ready is high and no write
//   is settling. Bucket boundaries are found by comparing b*m against offset*bucket_count;
//   b*m is carried incrementally. The sample closing a point passes the queue stage, then
//   the store read and reduction stage; the point is presented from the output register.
// Reset: registers take their reset values; the max-hold store is not swept,
//   a fill count marks bins not yet written since the last clear as -150 dBm.
// Stall: while out_ch.ready is low the point is held; a 4-entry queue keeps
//   accepting samples until it fills.
module spectrum_max_hold_peak_decimator_unit import smhpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  smhpd_in_if.sink    in_ch,
  smhpd_out_if.source out_ch,
  smhpd_cfg_if.sink   cfg_ch
);

  logic   q_push, q_full, q_valid, q_pop;
  q_ent_t q_ent, q_head;
  cfgd_t  cfgd;

  smhpd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_ent  (q_ent),
    .cfgd   (cfgd)
  );

  smhpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ent   (q_ent),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_ent   (q_head)
  );

  smhpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfgd    (cfgd),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for the max-hold peak decimator, directed cases then random sweeps
// depends on smhpd_pkg, smhpd_ifs and spectrum_max_hold_peak_decimator_unit
`timescale 1ns / 1ps

module testbench;
  import smhpd_pkg::*;

  localparam int BINS         = MAX_POINTS;
  localparam int RANDOM_ITEMS = 1030;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_MAX   = 10;
  localparam logic [REG_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    freq_t freq;
    amp_t  amp;
  } sample_t;

  typedef struct packed {
    freq_t freq;
    amp_t  live;
    amp_t  hold;
    logic  hv;
    logic  te;
  } trace_point_t;

  logic clk;
  logic rst_n;

  smhpd_in_if  in_ch ();
  smhpd_out_if out_ch ();
  smhpd_cfg_if cfg_ch ();

  spectrum_max_hold_peak_decimator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow registers and sweep state of the decimator
  cnt_t        sweep_reg;
  idx_t        first_reg;
  idx_t        last_reg;
  cnt_t        buckets_reg;
  logic        hold_en_reg;
  amp_t        hold_bins [BINS];
  int unsigned sweep_pos;
  int unsigned bucket_idx;
  freq_t       bucket_f0;
  amp_t        live_max;
  amp_t        held_max;

  sample_t      pending_samples [$];
  trace_point_t expected_points [$];
  int           queued_count;
  int           accepted_count;
  int           fail_count;
  int           cycle_count;
  int           in_gap;
  int           in_calm;
  int           stall_left;
  int           out_calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void restart_sweep();
    for (int k = 0; k < BINS; k++) hold_bins[k] = HOLD_FLOOR;
    sweep_pos  = 0;
    bucket_idx = 0;
    bucket_f0  = '0;
    live_max   = HOLD_FLOOR;
    held_max   = HOLD_FLOOR;
  endfunction

  // raises the hold bin, folds the sample into its bucket, returns 1 when a point comes out
  function automatic bit reduce_sample(input freq_t f, input amp_t a, output trace_point_t pt);
    int unsigned n, wf, wl, m, nb, i, o, b, bstart, bend;
    amp_t h;
    logic [FREQ_W:0] fsum;
    bit emit;
    emit = 1'b0;
    pt = '0;
    n = sweep_reg;
    if (n == 0) n = 1;
    if (n > BINS) n = BINS;
    wf = first_reg;
    wl = last_reg;
    if (wl > n - 1) wl = n - 1;
    if (wl < wf) begin
      wf = 0;
      wl = n - 1;
    end
    m = wl - wf + 1;
    nb = buckets_reg;
    if (nb < MIN_BUCKETS) nb = MIN_BUCKETS;
    i = sweep_pos;
    if (i >= n) i = 0;
    h = hold_bins[i];
    if (a > h) h = a;
    hold_bins[i] = h;
    if (i >= wf && i <= wl) begin
      o = i - wf;
      if (m <= nb) begin
        pt.freq = f;
        pt.live = a;
        pt.hold = h;
        pt.te   = (o == m - 1);
        emit    = 1'b1;
      end else begin
        if (o == 0) bucket_idx = 0;
        b      = bucket_idx;
        bstart = (b * m) / nb;
        bend   = ((b + 1) * m) / nb;
        if (o == 0 || o == bstart) begin
          bucket_f0 = f;
          live_max  = a;
          held_max  = h;
        end else begin
          if (a > live_max) live_max = a;
          if (h > held_max) held_max = h;
        end
        // bucket numbers past the count stay silent until the window reopens
        if (o + 1 >= bend && b < nb) begin
          fsum       = {1'b0, bucket_f0} + {1'b0, f};
          pt.freq    = fsum[FREQ_W:1];
          pt.live    = live_max;
          pt.hold    = held_max;
          pt.te      = (o == m - 1);
          emit       = 1'b1;
          bucket_idx = (b + 1) % 8192;
        end
      end
      if (emit) begin
        pt.hv = hold_en_reg;
        if (!hold_en_reg) pt.hold = '0;
      end
    end
    i++;
    if (i >= n) i = 0;
    sweep_pos = i;
    return emit;
  endfunction

  task automatic write_reg(input logic [REG_W-1:0] idx, input cnt_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_SWEEP_POINTS: begin
        sweep_reg = value;
        restart_sweep();
      end
      REG_WINDOW_FIRST: first_reg = value[IDX_W-1:0];
      REG_WINDOW_LAST:  last_reg = value[IDX_W-1:0];
      REG_BUCKET_COUNT: buckets_reg = value;
      REG_HOLD_ENABLE:  hold_en_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input freq_t f, input amp_t a);
    pending_samples.push_back('{freq: f, amp: a});
    queued_count++;
  endtask

  // zero-result samples may still be in the pipe when the last point arrives
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin : sample_driver
    trace_point_t pt;
    sample_t s;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (reduce_sample(in_ch.frequency, in_ch.amplitude, pt)) expected_points.push_back(pt);
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s = pending_samples.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.frequency <= s.freq;
          in_ch.amplitude <= s.amp;
          in_gap = next_gap(in_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : point_monitor
    trace_point_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected point: freq=%0d live=%0d hold=%0d hv=%0b end=%0b",
                     out_ch.point_frequency, out_ch.live_peak, out_ch.hold_peak,
                     out_ch.hold_valid, out_ch.trace_end);
        end else begin
          want = expected_points.pop_front();
          if (out_ch.point_frequency !== want.freq || out_ch.live_peak !== want.live ||
              out_ch.hold_peak !== want.hold || out_ch.hold_valid !== want.hv ||
              out_ch.trace_end !== want.te) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("point mismatch: exp freq=%0d live=%0d hold=%0d hv=%0b end=%0b,",
                       want.freq, want.live, want.hold, want.hv, want.te,
                       " got freq=%0d live=%0d hold=%0d hv=%0b end=%0b",
                       out_ch.point_frequency, out_ch.live_peak, out_ch.hold_peak,
                       out_ch.hold_valid, out_ch.trace_end);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = next_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int   random_items, eff, items, r;
    cnt_t v;
    freq_t f_ramp, f_step;
    amp_t a;
    freq_t f;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.frequency = '0;
    in_ch.amplitude = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    sweep_reg       = SWEEP_POINTS_RST;
    first_reg       = WINDOW_FIRST_RST;
    last_reg        = WINDOW_LAST_RST;
    buckets_reg     = BUCKET_COUNT_RST;
    hold_en_reg     = 1'b0;
    restart_sweep();
    queued_count   = 0;
    accepted_count = 0;
    fail_count     = 0;
    cycle_count    = 0;
    in_gap = 0;
    in_calm = 0;
    stall_left = 0;
    out_calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, hold off: four-sample buckets over the full sweep
    push_sample('0, 16'sh8000);
    push_sample(23'h7FFFFF, 16'sh7FFF);
    push_sample(23'h2AAAAA, -16'sd15000);
    push_sample(23'h555555, -16'sd15001);
    push_sample(23'h7FFFFF, 16'sh7FFF);
    push_sample(23'h7FFFFF, 16'sh8000);
    push_sample('0, 16'sh0000);
    push_sample(23'h000001, 16'shFFFF);
    wait_drained();

    // zero sweep length acts as one: every sample is the whole window
    write_reg(REG_HOLD_ENABLE, 13'd1);
    write_reg(REG_SWEEP_POINTS, 13'd0);
    push_sample(23'h7FFFFF, 16'sh8000);
    push_sample('0, -16'sd15001);
    push_sample(23'h400000, -16'sd14999);
    push_sample(23'h3FFFFF, 16'sh7FFF);
    push_sample(23'h000001, 16'sh0000);
    wait_drained();

    // window end past the sweep gets clipped
    write_reg(REG_SWEEP_POINTS, 13'd3);
    write_reg(REG_WINDOW_FIRST, 13'd2);
    write_reg(REG_WINDOW_LAST, 13'h1FFF);
    for (int k = 0; k < 6; k++) push_sample(freq_t'($urandom), amp_t'($urandom));
    wait_drained();

    // last below first opens the whole sweep; tiny bucket count is raised to the minimum
    write_reg(REG_WINDOW_FIRST, 13'd1);
    write_reg(REG_WINDOW_LAST, 13'd0);
    write_reg(REG_BUCKET_COUNT, 13'd0);
    for (int k = 0; k < 3; k++) push_sample(freq_t'($urandom), amp_t'($urandom));
    wait_drained();

    random_items = 0;
    f_ramp = '0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 35) begin
        r = $urandom_range(0, 99);
        if (r < 4) v = '0;
        else if (r < 8) v = cnt_t'($urandom_range(BINS + 1, 8191));
        else if (r < 12) v = cnt_t'(BINS);
        else if (r < 35) v = cnt_t'($urandom_range(1, 64));
        else v = cnt_t'($urandom_range(65, 300));
        write_reg(REG_SWEEP_POINTS, v);
      end
      eff = (sweep_reg == 0) ? 1 : ((sweep_reg > BINS) ? BINS : int'(sweep_reg));
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 50) v = '0;
        else if (r < 80) v = cnt_t'($urandom_range(0, eff - 1));
        else v = cnt_t'($urandom_range(0, 8191));
        write_reg(REG_WINDOW_FIRST, v);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 40) v = cnt_t'(BINS - 1);
        else if (r < 80) v = cnt_t'($urandom_range(first_reg, eff - 1));
        else v = cnt_t'($urandom_range(0, 8191));
        write_reg(REG_WINDOW_LAST, v);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 50) v = MIN_BUCKETS;
        else if (r < 70) v = cnt_t'($urandom_range(0, 63));
        else if (r < 90) v = cnt_t'($urandom_range(65, 200));
        else if (r < 95) v = cnt_t'(BINS);
        else v = 13'h1FFF;
        write_reg(REG_BUCKET_COUNT, v);
      end
      if ($urandom_range(0, 1)) write_reg(REG_HOLD_ENABLE, cnt_t'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 8) write_reg(REG_SPARE, cnt_t'($urandom_range(0, 8191)));

      items = eff * int'($urandom_range(1, 3));
      if (items < 24) items = 24;
      if (items > 240) items = 240;
      if (items > RANDOM_ITEMS - random_items) items = RANDOM_ITEMS - random_items;
      f_step = freq_t'($urandom_range(1, 5000));
      for (int k = 0; k < items; k++) begin
        // mostly a rising sweep, now and then a jump or an edge value
        f_ramp = f_ramp + f_step;
        r = $urandom_range(0, 15);
        if (r == 0) f = freq_t'($urandom);
        else if (r == 1) f = ($urandom_range(0, 1)) ? 23'h7FFFFF : '0;
        else f = f_ramp;
        r = $urandom_range(0, 99);
        if (r < 10) a = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
        else if (r < 25) a = HOLD_FLOOR + amp_t'($urandom_range(0, 6)) - 16'sd3;
        else a = amp_t'($urandom);
        push_sample(f, a);
      end
      random_items += items;
      wait_drained();
    end

    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
